@@ rtl/core/vrga_pkg.sv @@
// Shared types, constants and helper functions for the vertical row group averager.
`timescale 1ns / 1ps
`default_nettype none

package vrga_pkg;

   // Sizes of the line store and of the register fields.
   localparam int MAX_LINE   = 4096;
   localparam int ROWS_CAP   = 4096;
   localparam int HEIGHT_CAP = 4096;
   localparam int COL_W      = $clog2(MAX_LINE);
   localparam int LINE_W     = 12;
   localparam int COUNT_W    = 13;
   localparam int SAMPLE_W   = 16;
   localparam int NARROW_W   = 8;
   localparam int SUM_W      = 28;
   localparam int REM_W      = COUNT_W - 1;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int INDEX_W    = 3;

   // Configuration register indexes.
   typedef enum logic [INDEX_W-1:0] {
      REG_GROUP_ROWS   = 3'd0,
      REG_WHOLE_FRAME  = 3'd1,
      REG_LINE_LENGTH  = 3'd2,
      REG_FRAME_HEIGHT = 3'd3,
      REG_WIDE_SAMPLES = 3'd4,
      REG_BIG_ENDIAN   = 3'd5
   } vrga_reg_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_OUTPUT
   } vrga_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic accum;
      logic div_step;
      logic load_out;
   } vrga_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
      logic div_last;
      logic out_free;
   } vrga_status_type;

   // Swap the two bytes of a 16-bit value.
   function automatic logic [SAMPLE_W-1:0] swap16(input logic [SAMPLE_W-1:0] v);
      return {v[NARROW_W-1:0], v[SAMPLE_W-1:NARROW_W]};
   endfunction

   // A count of zero acts as one, and a count above the cap saturates.
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] cap);
      logic [COUNT_W-1:0] r;
      if (v == '0) begin
         r = COUNT_W'(1);
      end else if (v > cap) begin
         r = cap;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/vrga_if.sv @@
// Handshake channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface vrga_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface vrga_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] average;
   logic        line_end;
   logic        frame_end;

   modport source (output valid, output average, output line_end, output frame_end,
                   input ready);
   modport sink   (input valid, input average, input line_end, input frame_end,
                   output ready);
endinterface

interface vrga_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [12:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vrga_divider.sv @@
// Restoring divider that retires one quotient bit per cycle while step is asserted.
`timescale 1ns / 1ps
`default_nettype none

module vrga_divider (
   input  wire logic                          clock,
   input  wire logic                          start,
   input  wire logic                          step,
   input  wire logic [vrga_pkg::SUM_W-1:0]    dividend,
   input  wire logic [vrga_pkg::COUNT_W-1:0]  divisor,
   output logic      [vrga_pkg::SAMPLE_W-1:0] quotient,
   output logic                               last
);
   import vrga_pkg::*;

   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0] divisor_ff;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] trial;
   logic [COUNT_W-1:0] diff;
   logic               ge;

   // One trial subtraction; the quotient bit shifts into the dividend register.
   always_comb begin
      trial   = {rem_ff, dvd_ff[SUM_W-1]};
      diff    = trial - divisor_ff;
      ge      = (trial >= divisor_ff);
      rem_in  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd_in  = {dvd_ff[SUM_W-2:0], ge};
      step_in = step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         step_ff    <= '0;
      end else if (step) begin
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         step_ff <= step_in;
      end
   end

   assign quotient = dvd_ff[SAMPLE_W-1:0];
   assign last     = (step_ff == STEP_W'(DIV_STEPS - 1));

endmodule

`default_nettype wire

@@ rtl/core/vrga_ctrl.sv @@
// Controller state machine that sequences accept, accumulate, divide and output.
`timescale 1ns / 1ps
`default_nettype none

module vrga_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire vrga_pkg::vrga_status_type status,
   output vrga_pkg::vrga_cmd_type         cmd
);
   import vrga_pkg::*;

   vrga_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A line that emits nothing frees the block right after its store update.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && !status.emit) |=> (state_ff == ST_IDLE))
      else $error("non-emitting item did not return to idle");

   // The divider runs to its last step before the result is offered.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_last) |=> (state_ff == ST_OUTPUT))
      else $error("divider finish did not lead to output");

   // The output register is never overwritten while it holds an untaken beat.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("output register loaded while occupied");

endmodule

`default_nettype wire

@@ rtl/core/vrga_datapath.sv @@
// Datapath: registers, line counters, column sum store, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module vrga_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vrga_pkg::vrga_cmd_type        cmd,
   output vrga_pkg::vrga_status_type          status,
   input  wire logic [vrga_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                          csr_valid,
   input  wire logic [vrga_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [vrga_pkg::COUNT_W-1:0]  csr_data,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic      [vrga_pkg::SAMPLE_W-1:0] rsp_average,
   output logic                               rsp_line_end,
   output logic                               rsp_frame_end
);
   import vrga_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0] group_rows_ff, line_length_ff, frame_height_ff;
   logic               whole_frame_ff, wide_ff, big_endian_ff;
   logic               restart;

   // Position counters.
   logic [COL_W-1:0]   col_ff, col_in;
   logic [LINE_W-1:0]  group_line_ff, group_line_in;
   logic [LINE_W-1:0]  frame_line_ff, frame_line_in;

   // Per-item values held from accept to output.
   logic [SAMPLE_W-1:0] sample_ff;
   logic [COL_W-1:0]    addr_ff;
   logic [SUM_W-1:0]    rd_ff;
   logic                first_ff, emit_ff, line_end_ff, frame_end_ff, swap_ff;
   logic [COUNT_W-1:0]  divisor_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] average_ff;
   logic                out_line_end_ff, out_frame_end_ff;

   // Column sum store.
   logic [SUM_W-1:0]    sums_mem [MAX_LINE];

   logic [SAMPLE_W-1:0] s_in, s_proc;
   logic                swap;
   logic                line_last, first, emit, frame_last;
   logic [COUNT_W-1:0]  col_next, g_next, f_next, lines_left, divisor;
   logic [SUM_W-1:0]    sum;
   logic [SAMPLE_W-1:0] quotient;
   logic                div_last;

   // Register writes; every known index restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         group_rows_ff   <= COUNT_W'(2);
         whole_frame_ff  <= 1'b0;
         line_length_ff  <= COUNT_W'(640);
         frame_height_ff <= COUNT_W'(480);
         wide_ff         <= 1'b0;
         big_endian_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GROUP_ROWS:   group_rows_ff   <= clamp_count(csr_data, COUNT_W'(ROWS_CAP));
            REG_WHOLE_FRAME:  whole_frame_ff  <= csr_data[0];
            REG_LINE_LENGTH:  line_length_ff  <= clamp_count(csr_data, COUNT_W'(MAX_LINE));
            REG_FRAME_HEIGHT: frame_height_ff <= clamp_count(csr_data, COUNT_W'(HEIGHT_CAP));
            REG_WIDE_SAMPLES: wide_ff         <= csr_data[0];
            REG_BIG_ENDIAN:   big_endian_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index) inside
         REG_GROUP_ROWS, REG_WHOLE_FRAME, REG_LINE_LENGTH,
         REG_FRAME_HEIGHT, REG_WIDE_SAMPLES, REG_BIG_ENDIAN: restart = csr_valid;
         default: restart = 1'b0;
      endcase
   end

   // Sample format and the flags of the current position.
   always_comb begin
      swap   = wide_ff && big_endian_ff;
      s_in   = wide_ff ? req_sample : {{(SAMPLE_W - NARROW_W){1'b0}}, req_sample[NARROW_W-1:0]};
      s_proc = swap ? swap16(s_in) : s_in;

      col_next   = {1'b0, col_ff} + COUNT_W'(1);
      g_next     = {1'b0, group_line_ff} + COUNT_W'(1);
      f_next     = {1'b0, frame_line_ff} + COUNT_W'(1);
      lines_left = frame_height_ff - f_next;
      line_last  = (col_next >= line_length_ff);

      if (whole_frame_ff) begin
         first      = (frame_line_ff == '0);
         emit       = (f_next >= frame_height_ff);
         frame_last = emit;
         divisor    = frame_height_ff;
      end else begin
         // A group's last line is complete by construction; it closes the
         // frame when no further whole group fits below it.
         first      = (group_line_ff == '0);
         emit       = (g_next >= group_rows_ff);
         frame_last = emit && (lines_left < group_rows_ff);
         divisor    = group_rows_ff;
      end
   end

   // Next position after the accepted beat.
   always_comb begin
      col_in        = col_ff;
      group_line_in = group_line_ff;
      frame_line_in = frame_line_ff;
      if (line_last) begin
         col_in        = '0;
         group_line_in = (g_next >= group_rows_ff) ? '0 : g_next[LINE_W-1:0];
         frame_line_in = f_next[LINE_W-1:0];
         if (f_next >= frame_height_ff) begin
            group_line_in = '0;
            frame_line_in = '0;
         end
      end else begin
         col_in = col_next[COL_W-1:0];
      end
   end

   // Position counters.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff        <= '0;
         group_line_ff <= '0;
         frame_line_ff <= '0;
      end else if (cmd.accept) begin
         col_ff        <= col_in;
         group_line_ff <= group_line_in;
         frame_line_ff <= frame_line_in;
      end
   end

   // Item registers captured on accept.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff    <= s_proc;
         addr_ff      <= col_ff;
         first_ff     <= first;
         emit_ff      <= emit;
         line_end_ff  <= line_last;
         frame_end_ff <= line_last && frame_last;
         swap_ff      <= swap;
         divisor_ff   <= divisor;
      end
   end

   // Column sum store: read on accept, write back on accumulate.
   always_comb begin
      sum = first_ff ? {{(SUM_W - SAMPLE_W){1'b0}}, sample_ff}
                     : rd_ff + {{(SUM_W - SAMPLE_W){1'b0}}, sample_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= sums_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         sums_mem[addr_ff] <= sum;
      end
   end

   vrga_divider u_divider (
      .clock    (clock),
      .start    (cmd.accum),
      .step     (cmd.div_step),
      .dividend (sum),
      .divisor  (divisor_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         average_ff       <= swap_ff ? swap16(quotient) : quotient;
         out_line_end_ff  <= line_end_ff;
         out_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_average   = average_ff;
   assign rsp_line_end  = out_line_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

   assign status.emit     = emit_ff;
   assign status.div_last = div_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // The frame line counter stays inside the configured frame.
   assert property (@(posedge clock) disable iff (reset)
      frame_line_ff < frame_height_ff)
      else $error("frame line counter out of range");

   // The group line counter stays inside the configured group.
   assert property (@(posedge clock) disable iff (reset)
      group_line_ff < group_rows_ff)
      else $error("group line counter out of range");

   // A result beat appears only after the controller loaded one.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result beat without output load");

endmodule

`default_nettype wire

@@ rtl/core/vertical_row_group_average.sv @@
// Top level of the vertical row group averager.
`timescale 1ns / 1ps
`default_nettype none

// Sums each column over runs of group_rows lines (or over a whole frame) and
// emits the truncated column average on the last line of each run, one result
// beat per sample of that line. For every input beat the column sum is read
// from the 4096-entry line store on accept and written back on the next cycle.
// A beat that produces a result then goes through the restoring divider, which
// retires one quotient bit per cycle, and waits for the result register to drain
// before that register is loaded. A new input beat is accepted only while the
// block is idle. The line store needs no clearing after reset, because the
// first line of every group or frame loads its sums instead of adding to them.
// Register writes are taken in any cycle but must only be issued while the
// block is idle; each write to a known register restarts the frame.
module vertical_row_group_average (
   input  wire logic  clock,
   input  wire logic  reset,
   vrga_req_if.sink   req_bus,
   vrga_rsp_if.source rsp_bus,
   vrga_csr_if.sink   csr_bus
);
   import vrga_pkg::*;

   vrga_cmd_type    cmd;
   vrga_status_type status;

   assign csr_bus.ready = 1'b1;

   vrga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vrga_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample    (req_bus.sample),
      .csr_valid     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_average   (rsp_bus.average),
      .rsp_line_end  (rsp_bus.line_end),
      .rsp_frame_end (rsp_bus.frame_end)
   );

endmodule

`default_nettype wire
